// ===== sv/dpm_pkg.sv =====
`default_nettype none
package dpm_pkg;

  localparam int unsigned PAGE_BITS = 12;
  localparam int unsigned VPN_BITS  = 10;
  localparam int unsigned PA_W      = 20;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_SRD,
    S_SCHK,
    S_RDW,
    S_RLRD,
    S_RLCK,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/dpm_ram.sv =====
`default_nettype none
module dpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/demand_paged_memory.sv =====
// Demand-paged byte memory with per-table single-level page tables.
// Input channel (in_valid/in_stall): one byte access per word: write, read or
// release of a whole table. Output channel (out_valid/out_stall): exactly one
// result word per input word, in order.
// An item is taken only while the sequencer is idle; in_stall is high during
// all other work. Steps per kind after accept:
//   write to a mapped page, fault, other kinds: page-table lookup, then done
//   read of a mapped page: page-table lookup, byte-store read, then done
//   write to an unmapped page: page-table lookup, then a free-frame scan
//     (the scan starts at a low-water mark of the lowest possibly free frame)
//   release: a sweep over all 1024 page-table entries of the table
// A new item is taken only after the last result is loaded for output.
// The page table, the frame-use map and the byte store are RAMs with one write
// and one registered read port; each serves one lookup per cycle.
// After reset a clearing pass zeroes all three RAMs, one address per cycle;
// no item is taken meanwhile.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and finishes once the register frees up.
`default_nettype none
module demand_paged_memory #(
  parameter int unsigned TABLES     = 4,
  parameter int unsigned PHYS_PAGES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [1:0]  in_table_id,
  input  wire logic [21:0] in_virtual_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_request_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data,
  output logic [1:0]       out_status,
  output logic [19:0]      out_physical_address,
  output logic             out_result_end
);
  import dpm_pkg::*;

  localparam int unsigned FW       = $clog2(PHYS_PAGES);
  localparam int unsigned TW       = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int unsigned PT_DEPTH = TABLES * 1024;
  localparam int unsigned PW       = $clog2(PT_DEPTH);
  localparam int unsigned ST_DEPTH = PHYS_PAGES * 4096;
  localparam int unsigned AW       = $clog2(ST_DEPTH);
  localparam int unsigned CLR_N    = (ST_DEPTH > PT_DEPTH) ? ST_DEPTH : PT_DEPTH;
  localparam int unsigned CW       = $clog2(CLR_N);

  state_t state_r, state_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [TW-1:0] tbl_r, tbl_nxt;
  logic [VPN_BITS-1:0] vpn_r, vpn_nxt, sweep_r, sweep_nxt;
  logic [PAGE_BITS-1:0] off_r, off_nxt;
  logic [7:0] wd_r, wd_nxt;
  logic end_r, end_nxt;
  logic [FW-1:0] srch_r, srch_nxt;
  logic [FW:0] hint_r, hint_nxt;
  logic [7:0] res_data_r, res_data_nxt;
  logic [1:0] res_st_r, res_st_nxt;
  logic [PA_W-1:0] res_pa_r, res_pa_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic [1:0] out_st_r, out_st_nxt;
  logic [PA_W-1:0] out_pa_r, out_pa_nxt;
  logic out_end_r, out_end_nxt;

  // RAM ports
  logic pt_we;
  logic [PW-1:0] pt_waddr, pt_raddr;
  logic [FW:0] pt_wdata, pt_q;
  logic fu_we;
  logic [FW-1:0] fu_waddr, fu_raddr;
  logic [0:0] fu_wdata, fu_q;
  logic st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0] st_wdata, st_q;

  logic [2:0] tmod;
  logic [TW-1:0] in_tbl;
  logic [PW-1:0] in_ent, cur_ent, sweep_ent;
  logic [AW-1:0] map_addr, new_addr;
  logic [AW+PA_W-1:0] map_wide, new_wide;
  logic out_free, clr_last, accept;

  dpm_ram #(.WIDTH(FW+1), .DEPTH(PT_DEPTH)) u_pt (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_q)
  );
  dpm_ram #(.WIDTH(1), .DEPTH(PHYS_PAGES)) u_fu (
    .clk(clk), .we(fu_we), .waddr(fu_waddr), .wdata(fu_wdata),
    .raddr(fu_raddr), .rdata(fu_q)
  );
  dpm_ram #(.WIDTH(8), .DEPTH(ST_DEPTH)) u_st (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_q)
  );

  // table_id wraps when fewer than four tables exist
  always_comb begin
    tmod = {1'b0, in_table_id};
    for (int i = 0; i < 3; i++) begin
      if (32'(tmod) >= TABLES) begin
        tmod = tmod - 3'(TABLES);
      end
    end
    in_tbl = TW'(tmod);
  end

  assign in_ent    = PW'({in_tbl, in_virtual_address[21:12]});
  assign cur_ent   = PW'({tbl_r, vpn_r});
  assign sweep_ent = PW'({tbl_r, sweep_r});
  assign map_addr  = {pt_q[FW-1:0], off_r};
  assign new_addr  = {srch_r, off_r};
  assign map_wide  = (AW+PA_W)'(map_addr);
  assign new_wide  = (AW+PA_W)'(new_addr);
  assign out_free  = !out_valid_r || !out_stall;
  assign clr_last  = (clr_r == CW'(CLR_N - 1));
  assign accept    = (state_r == S_IDLE) && in_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        case (kind_r)
          KIND_WRITE: begin
            if (pt_q[FW]) state_nxt = S_DONE;
            else if (hint_r >= (FW+1)'(PHYS_PAGES)) state_nxt = S_DONE;
            else state_nxt = S_SRD;
          end
          KIND_READ:    state_nxt = pt_q[FW] ? S_RDW : S_DONE;
          KIND_RELEASE: state_nxt = S_RLRD;
          default:      state_nxt = S_DONE;
        endcase
      end
      S_SRD: state_nxt = S_SCHK;
      S_SCHK: begin
        if (!fu_q[0] || srch_r == FW'(PHYS_PAGES - 1)) state_nxt = S_DONE;
        else state_nxt = S_SRD;
      end
      S_RDW:  state_nxt = S_DONE;
      S_RLRD: state_nxt = S_RLCK;
      S_RLCK: state_nxt = (sweep_r == '1) ? S_DONE : S_RLRD;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    clr_nxt = clr_r;
    kind_nxt = kind_r; tbl_nxt = tbl_r; vpn_nxt = vpn_r; off_nxt = off_r;
    wd_nxt = wd_r; end_nxt = end_r;
    srch_nxt = srch_r; hint_nxt = hint_r; sweep_nxt = sweep_r;
    res_data_nxt = res_data_r; res_st_nxt = res_st_r; res_pa_nxt = res_pa_r;
    out_valid_nxt = out_valid_r; out_data_nxt = out_data_r; out_st_nxt = out_st_r;
    out_pa_nxt = out_pa_r; out_end_nxt = out_end_r;
    pt_we = 1'b0; pt_waddr = cur_ent; pt_wdata = '0; pt_raddr = cur_ent;
    fu_we = 1'b0; fu_waddr = srch_r; fu_wdata = 1'b0; fu_raddr = srch_r;
    st_we = 1'b0; st_waddr = map_addr; st_wdata = wd_r; st_raddr = map_addr;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        pt_we    = ({1'b0, clr_r} < (CW+1)'(PT_DEPTH));
        pt_waddr = clr_r[PW-1:0];
        fu_we    = ({1'b0, clr_r} < (CW+1)'(PHYS_PAGES));
        fu_waddr = clr_r[FW-1:0];
        st_we    = 1'b1;
        st_waddr = clr_r[AW-1:0];
        st_wdata = '0;
      end
      S_IDLE: begin
        pt_raddr = in_ent;
        if (accept) begin
          kind_nxt = in_kind;
          tbl_nxt  = in_tbl;
          vpn_nxt  = in_virtual_address[21:12];
          off_nxt  = in_virtual_address[11:0];
          wd_nxt   = in_write_data;
          end_nxt  = in_request_end;
        end
        res_data_nxt = '0;
        res_st_nxt   = ST_OK;
        res_pa_nxt   = '0;
      end
      S_DEC: begin
        case (kind_r)
          KIND_WRITE: begin
            if (pt_q[FW]) begin
              st_we      = 1'b1;
              res_pa_nxt = map_wide[PA_W-1:0];
            end else if (hint_r >= (FW+1)'(PHYS_PAGES)) begin
              res_st_nxt = ST_NO_MEMORY;
            end else begin
              srch_nxt = hint_r[FW-1:0];
            end
          end
          KIND_READ: begin
            if (pt_q[FW]) res_pa_nxt = map_wide[PA_W-1:0];
            else res_st_nxt = ST_NOT_MAPPED;
          end
          KIND_RELEASE: sweep_nxt = '0;
          default: ;
        endcase
      end
      S_SCHK: begin
        if (!fu_q[0]) begin
          // claim this frame and map the page to it
          fu_we      = 1'b1;
          fu_wdata   = 1'b1;
          pt_we      = 1'b1;
          pt_wdata   = {1'b1, srch_r};
          st_we      = 1'b1;
          st_waddr   = new_addr;
          res_pa_nxt = new_wide[PA_W-1:0];
          hint_nxt   = (FW+1)'(srch_r) + 1'b1;
        end else if (srch_r == FW'(PHYS_PAGES - 1)) begin
          res_st_nxt = ST_NO_MEMORY;
          hint_nxt   = (FW+1)'(PHYS_PAGES);
        end else begin
          srch_nxt = srch_r + 1'b1;
        end
      end
      S_RDW: res_data_nxt = st_q;
      S_RLRD: pt_raddr = sweep_ent;
      S_RLCK: begin
        if (pt_q[FW]) begin
          pt_we    = 1'b1;
          pt_waddr = sweep_ent;
          pt_wdata = '0;
          fu_we    = 1'b1;
          fu_waddr = pt_q[FW-1:0];
          fu_wdata = 1'b0;
          if ((FW+1)'(pt_q[FW-1:0]) < hint_nxt) hint_nxt = (FW+1)'(pt_q[FW-1:0]);
        end
        sweep_nxt = sweep_r + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_st_nxt    = res_st_r;
          out_pa_nxt    = res_pa_r;
          out_end_nxt   = end_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    tbl_r      <= tbl_nxt;
    vpn_r      <= vpn_nxt;
    off_r      <= off_nxt;
    wd_r       <= wd_nxt;
    end_r      <= end_nxt;
    srch_r     <= srch_nxt;
    sweep_r    <= sweep_nxt;
    res_data_r <= res_data_nxt;
    res_st_r   <= res_st_nxt;
    res_pa_r   <= res_pa_nxt;
    out_data_r <= out_data_nxt;
    out_st_r   <= out_st_nxt;
    out_pa_r   <= out_pa_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_read_data        = out_data_r;
  assign out_status           = out_st_r;
  assign out_physical_address = out_pa_r;
  assign out_result_end       = out_end_r;
endmodule
`default_nettype wire

// ===== sv/dpm_check.sv =====
`default_nettype none
module dpm_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_read_data,
  input wire logic [1:0]  out_status,
  input wire logic [19:0] out_physical_address
);
  import dpm_pkg::*;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_physical_address)
      && $stable(out_status) && $stable(out_read_data))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_NOT_MAPPED
      || out_status == ST_NO_MEMORY)
    else $error("bad status code");

  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_physical_address == 20'd0
      && out_read_data == 8'd0)
    else $error("fault carries data");

  // one item in flight: no accept directly follows another
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken back to back");
endmodule

bind demand_paged_memory dpm_check u_dpm_check (.*);
`default_nettype wire
